// ----- src/box_blur_3x3_rgba_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 box blur
// Implication checks in the same cycle and in the next cycle; empty bodies
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGBA_MACROS_SVH
`define BOX_BLUR_3X3_RGBA_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BBR_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// next-cycle implication
`define BBR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define BBR_ASSERT_IMPL(name, clk, rst, ante, cons)
`define BBR_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ----- src/bbr_pkg.sv -----
// ----------------------------------------------------------------------------
// Box blur package
// Widths, types, divisor codes and reciprocal constants shared by the blur.
// ----------------------------------------------------------------------------
`default_nettype none

package bbr_pkg;

   localparam int PIXEL_W          = 32;
   localparam int LANES            = 4;
   localparam int LANE_W           = 8;
   localparam int CFG_W            = 11;
   localparam int POS_W            = 10;
   localparam int RSP_DATA_W       = 56;
   localparam int DEFAULT_MAX_SIZE = 1024;
   localparam int IMAGE_SIZE_RESET = 1024;
   localparam int ROWS             = 3;
   localparam int COL_SUM_W        = 10;   // three lanes of 255
   localparam int WIN_SUM_W        = 12;   // nine lanes of 255
   localparam int PROD_W           = 25;

   // truncating reciprocals, exact for every sum a window can reach
   localparam int RECIP_6     = 5462;
   localparam int RECIP_9     = 3641;
   localparam int RECIP_SHIFT = 15;

   // divisor select
   localparam logic [1:0] DIV_BY_4 = 2'd0;
   localparam logic [1:0] DIV_BY_6 = 2'd1;
   localparam logic [1:0] DIV_BY_9 = 2'd2;

   typedef logic [PIXEL_W-1:0]                 pixel_type;
   typedef pixel_type [ROWS-1:0]               column_type;
   typedef logic [LANES-1:0][COL_SUM_W-1:0]    col_sum_type;
   typedef logic [LANES-1:0][WIN_SUM_W-1:0]    win_sum_type;

   // lane sums of one window column: all three rows, or the lower two
   typedef struct packed {
      col_sum_type full;
      col_sum_type lower;
   } cell_sums_type;

endpackage

`default_nettype wire

// ----- src/bbr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- src/bbr_cell.sv -----
// ----------------------------------------------------------------------------
// Window column cell
// Holds one three-pixel column of the window, hands it on to the next cell
// on each shift and gives its per-lane column sums.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr_cell
   import bbr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          shift_en,
   input  wire column_type    col_in,
   output column_type         col_out,
   output cell_sums_type      sums
);

   column_type col_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         sums.lower[k] = COL_SUM_W'(col_ff[1][LANE_W*k +: LANE_W])
                       + COL_SUM_W'(col_ff[2][LANE_W*k +: LANE_W]);
         sums.full[k]  = sums.lower[k] + COL_SUM_W'(col_ff[0][LANE_W*k +: LANE_W]);
      end
   end

endmodule

`default_nettype wire

// ----- src/bbr_mean.sv -----
// ----------------------------------------------------------------------------
// Window mean
// Divides the four lane sums by 4, 6 or 9 through truncating reciprocals.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr_mean
   import bbr_pkg::*;
(
   input  wire win_sum_type   win_sums,
   input  wire logic [1:0]    div_sel,
   output pixel_type          mean
);

   logic [LANES-1:0][PROD_W-1:0] prod6;
   logic [LANES-1:0][PROD_W-1:0] prod9;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         prod6[k] = PROD_W'(win_sums[k]) * PROD_W'(RECIP_6);
         prod9[k] = PROD_W'(win_sums[k]) * PROD_W'(RECIP_9);
         unique case (div_sel)
            DIV_BY_6: begin
               mean[LANE_W*k +: LANE_W] = prod6[k][RECIP_SHIFT +: LANE_W];
            end
            DIV_BY_9: begin
               mean[LANE_W*k +: LANE_W] = prod9[k][RECIP_SHIFT +: LANE_W];
            end
            default: begin
               mean[LANE_W*k +: LANE_W] = win_sums[k][2 +: LANE_W];
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- src/box_blur_3x3_rgba.sv -----
// ----------------------------------------------------------------------------
// 3x3 box blur over a square RGBA image
// Streams pixels in raster order and returns the clipped 3x3 lane means.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one 32-bit RGBA pixel per word, raster order, top row first.
//   rsp_* gives the blurred pixels, each with its row and column; rsp_tlast
//   marks the last result word caused by one request word. Row 0 gives no
//   result, a pixel at (r>=1, c>=1) gives the centre (r-1, c-1), and the row
//   and frame ends flush their extra centres, so the last pixel of a frame
//   gives four words.
//   csr_wr_en writes image_size (clamped to 2 .. MAX_SIZE) and restarts the
//   frame at pixel (0, 0); write it only with the block idle.
// Timing:
//   A word is taken in the idle state, which reads the line stores; the load
//   state shifts the window. Each result passes the sum state (window sum)
//   and the divide state (into the output register, held while it is not
//   free) of the single shared sum and divide path. The next request word is
//   taken as soon as the last result sits in the output register.
// Reset and stall:
//   Reset empties the output register, restarts at pixel (0, 0) and sets the
//   size to 1024. While rsp_tready is low the output word holds and the
//   sequencer waits with the next result; the line stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_blur_3x3_rgba_macros.svh"

module box_blur_3x3_rgba
   import bbr_pkg::*;
#(
   parameter int MAX_SIZE = DEFAULT_MAX_SIZE
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request: in_pixel[31:0]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [PIXEL_W-1:0]    req_tdata,
   // response: out_pixel[31:0], out_row[41:32], out_col[51:42], zero pad
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,   // last_in_run
   // configuration: image_size
   input  wire logic                  csr_wr_en,
   input  wire logic [CFG_W-1:0]      csr_wr_data
);

   localparam int CW = $clog2(MAX_SIZE);      // row and column counters
   localparam int SW = CW + 1;                // size, holds MAX_SIZE
   localparam int EW = 13;                    // room for any MAX_SIZE
   localparam logic [SW-1:0] SIZE_RESET =
      SW'((IMAGE_SIZE_RESET > MAX_SIZE) ? MAX_SIZE : IMAGE_SIZE_RESET);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_SUM  = 2'd2;
   localparam logic [1:0] ST_DIV  = 2'd3;

   // control
   logic [1:0]            state_ff, state_in;
   logic [SW-1:0]         size_ff, size_in;
   logic [CW-1:0]         row_count_ff, row_count_in;
   logic [CW-1:0]         col_count_ff, col_count_in;
   logic [3:0]            mask_ff, mask_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload
   pixel_type             pix_ff;
   logic [CW-1:0]         r_ff, c_ff;
   win_sum_type           win_sum_ff, win_sum_in;
   logic [1:0]            div_sel_ff, div_sel_in;
   logic [POS_W-1:0]      orow_ff, orow_in, ocol_ff, ocol_in;
   logic                  olast_ff, olast_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   logic                  req_accept;
   logic                  out_free;
   logic [EW-1:0]         csr_ext;
   logic [SW-1:0]         col_step, row_step;
   logic [CW-1:0]         size_last;
   logic                  r_ge1, c_ge1, r_ge2, c_ge2, r_end, c_end;
   logic [3:0]            pick;
   logic                  rows3, cols3, row_back, col_back;

   pixel_type             upper_rd, lower_rd;
   column_type            new_col;
   column_type            col_chain [3];
   cell_sums_type         cell_sums [3];
   pixel_type             mean_pix;
   logic                  shift_en;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign shift_en   = (state_ff == ST_LOAD);

   // --- size register, clamped on write ---
   always_comb begin
      csr_ext = EW'(csr_wr_data);
      if (csr_ext < EW'(2)) begin
         size_in = SW'(2);
      end else if (csr_ext > EW'(MAX_SIZE)) begin
         size_in = SW'(MAX_SIZE);
      end else begin
         size_in = SW'(csr_ext);
      end
   end

   // --- raster position of the next request word ---
   always_comb begin
      col_step     = SW'(col_count_ff) + SW'(1);
      row_step     = SW'(row_count_ff) + SW'(1);
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (csr_wr_en) begin
         col_count_in = '0;
         row_count_in = '0;
      end else if (req_accept) begin
         if (col_step >= size_ff) begin
            col_count_in = '0;
            row_count_in = (row_step >= size_ff) ? '0 : CW'(row_step);
         end else begin
            col_count_in = CW'(col_step);
         end
      end
   end

   // --- line stores: upper trails lower by one row ---
   bbr_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_SIZE)
   ) u_upper_store (
      .clock   (clock),
      .wr_en   (shift_en),
      .wr_addr (c_ff),
      .wr_data (lower_rd),
      .rd_en   (req_accept),
      .rd_addr (col_count_ff),
      .rd_data (upper_rd)
   );

   bbr_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_SIZE)
   ) u_lower_store (
      .clock   (clock),
      .wr_en   (shift_en),
      .wr_addr (c_ff),
      .wr_data (pix_ff),
      .rd_en   (req_accept),
      .rd_addr (col_count_ff),
      .rd_data (lower_rd)
   );

   // --- window: three column cells, newest column enters cell 2 ---
   always_comb begin
      new_col[0] = upper_rd;
      new_col[1] = lower_rd;
      new_col[2] = pix_ff;
   end

   bbr_cell u_cell2 (
      .clock    (clock),
      .shift_en (shift_en),
      .col_in   (new_col),
      .col_out  (col_chain[2]),
      .sums     (cell_sums[2])
   );

   bbr_cell u_cell1 (
      .clock    (clock),
      .shift_en (shift_en),
      .col_in   (col_chain[2]),
      .col_out  (col_chain[1]),
      .sums     (cell_sums[1])
   );

   bbr_cell u_cell0 (
      .clock    (clock),
      .shift_en (shift_en),
      .col_in   (col_chain[1]),
      .col_out  (col_chain[0]),
      .sums     (cell_sums[0])
   );

   // --- which centres this word completes ---
   always_comb begin
      size_last = CW'(size_ff - SW'(1));
      r_ge1     = (r_ff != '0);
      c_ge1     = (c_ff != '0);
      r_ge2     = (r_ff > CW'(1));
      c_ge2     = (c_ff > CW'(1));
      r_end     = (r_ff == size_last);
      c_end     = (c_ff == size_last);
   end

   // --- pick the next pending centre, lowest bit first ---
   always_comb begin
      pick     = 4'b0000;
      rows3    = 1'b0;
      cols3    = 1'b0;
      row_back = 1'b0;
      col_back = 1'b0;
      priority if (mask_ff[0]) begin
         // interior centre up and left
         pick     = 4'b0001;
         rows3    = r_ge2;
         cols3    = c_ge2;
         row_back = 1'b1;
         col_back = 1'b1;
      end else if (mask_ff[1]) begin
         // row end flush
         pick     = 4'b0010;
         rows3    = r_ge2;
         row_back = 1'b1;
      end else if (mask_ff[2]) begin
         // last row, centre to the left
         pick     = 4'b0100;
         cols3    = c_ge2;
         col_back = 1'b1;
      end else if (mask_ff[3]) begin
         // frame end flush
         pick     = 4'b1000;
      end

      for (int k = 0; k < LANES; k++) begin
         win_sum_in[k] =
              (cols3 ? WIN_SUM_W'(rows3 ? cell_sums[0].full[k] : cell_sums[0].lower[k])
                     : WIN_SUM_W'(0))
            + WIN_SUM_W'(rows3 ? cell_sums[1].full[k] : cell_sums[1].lower[k])
            + WIN_SUM_W'(rows3 ? cell_sums[2].full[k] : cell_sums[2].lower[k]);
      end

      if (rows3 && cols3) begin
         div_sel_in = DIV_BY_9;
      end else if (rows3 || cols3) begin
         div_sel_in = DIV_BY_6;
      end else begin
         div_sel_in = DIV_BY_4;
      end

      orow_in  = POS_W'(r_ff - CW'(row_back));
      ocol_in  = POS_W'(c_ff - CW'(col_back));
      olast_in = ((mask_ff & ~pick) == 4'b0000);
   end

   bbr_mean u_mean (
      .win_sums (win_sum_ff),
      .div_sel  (div_sel_ff),
      .mean     (mean_pix)
   );

   // --- sequencer ---
   always_comb begin
      state_in     = state_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mask_in  = {r_end && c_end, r_end && c_ge1, r_ge1 && c_end, r_ge1 && c_ge1};
            state_in = (r_ge1 && (c_ge1 || c_end)) ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            mask_in  = mask_ff & ~pick;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = (mask_ff != 4'b0000) ? ST_SUM : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_RESET;
         row_count_ff <= '0;
         col_count_ff <= '0;
         mask_ff      <= 4'b0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            size_ff <= size_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pix_ff <= req_tdata;
         r_ff   <= row_count_ff;
         c_ff   <= col_count_ff;
      end
      if (state_ff == ST_SUM) begin
         win_sum_ff <= win_sum_in;
         div_sel_ff <= div_sel_in;
         orow_ff    <= orow_in;
         ocol_ff    <= ocol_in;
         olast_ff   <= olast_in;
      end
      if (state_ff == ST_DIV && out_free) begin
         rsp_data_ff <= {(RSP_DATA_W - PIXEL_W - 2*POS_W)'(0), ocol_ff, orow_ff, mean_pix};
         rsp_last_ff <= olast_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // --- checks ---
   `BBR_ASSERT_NEXT(a_accept_loads, clock, reset, req_accept, state_ff == ST_LOAD)
   `BBR_ASSERT_NEXT(a_stall_holds, clock, reset,
                    state_ff == ST_DIV && rsp_valid_ff && !rsp_tready,
                    state_ff == ST_DIV && rsp_valid_ff)
   `BBR_ASSERT_IMPL(a_idle_no_pending, clock, reset, state_ff == ST_IDLE,
                    mask_ff == 4'b0000)
   `BBR_ASSERT_IMPL(a_position_in_frame, clock, reset, 1'b1,
                    SW'(col_count_ff) < size_ff && SW'(row_count_ff) < size_ff)

endmodule

`default_nettype wire

// ----- verif/box_blur_3x3_rgba_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur 3x3 RGBA testbench
// Streams square images through the blur and checks every result word
// against a lane-wise clipped-window mean computed here. A short table of
// directed words opens the run: reset size, clamped sizes, flat frames, frame
// wrap and a 3x3 frame of extreme values. Random phases follow, with sender
// gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------

module box_blur_3x3_rgba_tb;
   import bbr_pkg::*;

   localparam int MAX_SIDE        = DEFAULT_MAX_SIZE;
   localparam int SETTLE_CYCLES   = 12;     // longest item: four results
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int REPORT_CAP      = 200;
   localparam int ROW_LSB         = PIXEL_W;
   localparam int COL_LSB         = PIXEL_W + POS_W;
   localparam int PAD_LSB         = PIXEL_W + 2 * POS_W;
   localparam int NOT_TYPED       = -1;

   typedef enum logic {ROW_SIZE, ROW_PIXEL} plan_kind_type;

   typedef struct {
      plan_kind_type kind;
      logic [31:0]   value;
      int            typed_n;     // results read straight off the input, or NOT_TYPED
      pixel_type     typed_pix;   // every one of those results carries this pixel
   } plan_row_type;

   typedef struct {
      pixel_type        pix;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } blur_word_type;

   typedef struct {
      int        n;
      pixel_type pix;
   } typed_blur_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PIXEL_W-1:0]    req_tdata;     // in_pixel[31:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;     // out_pixel[31:0], out_row[41:32], out_col[51:42]
   logic                  rsp_tlast;     // last_in_run
   logic                  csr_wr_en;
   logic [CFG_W-1:0]      csr_wr_data;

   // shadow of the block: size register, two line stores, window, position
   logic [CFG_W-1:0] side_reg;
   pixel_type        older_row [MAX_SIDE];
   pixel_type        newer_row [MAX_SIDE];
   pixel_type        win [3][3];
   int unsigned      next_row;
   int unsigned      next_col;

   blur_word_type    expected_blurs [$];
   typed_blur_type   typed_blur_q [$];
   int unsigned      faults;
   int unsigned      req_idle_pct;
   int unsigned      rsp_stall_pct;
   int unsigned      hold_asks;

   // opening words: flat frames have results that need no arithmetic
   plan_row_type opening_plan [26] = '{
      '{ROW_PIXEL, 32'hFFFF_FFFF, 0, 32'h0},          // reset size, row 0: silent
      '{ROW_PIXEL, 32'h0000_0000, 0, 32'h0},
      '{ROW_SIZE,  32'd1,         NOT_TYPED, 32'h0},  // below range, acts as 2
      '{ROW_PIXEL, 32'hFFFF_FFFF, 0, 32'h0},
      '{ROW_PIXEL, 32'hFFFF_FFFF, 0, 32'h0},
      '{ROW_PIXEL, 32'hFFFF_FFFF, 0, 32'h0},
      '{ROW_PIXEL, 32'hFFFF_FFFF, 4, 32'hFFFF_FFFF},  // frame end: four words
      '{ROW_SIZE,  32'd0,         NOT_TYPED, 32'h0},
      '{ROW_PIXEL, 32'h0000_0000, 0, 32'h0},
      '{ROW_PIXEL, 32'h0000_0000, 0, 32'h0},
      '{ROW_PIXEL, 32'h0000_0000, 0, 32'h0},
      '{ROW_PIXEL, 32'h0000_0000, 4, 32'h0},
      // counters wrap, next frame without a write
      '{ROW_PIXEL, 32'h8080_8080, NOT_TYPED, 32'h0},
      '{ROW_PIXEL, 32'h7F7F_7F7F, NOT_TYPED, 32'h0},
      '{ROW_PIXEL, 32'h00FF_00FF, NOT_TYPED, 32'h0},
      '{ROW_PIXEL, 32'hFF00_FF00, NOT_TYPED, 32'h0},
      '{ROW_SIZE,  32'd3,         NOT_TYPED, 32'h0},
      '{ROW_PIXEL, 32'h0101_0101, NOT_TYPED, 32'h0},
      '{ROW_PIXEL, 32'hFEFE_FEFE, NOT_TYPED, 32'h0},
      '{ROW_PIXEL, 32'h1234_5678, NOT_TYPED, 32'h0},
      '{ROW_PIXEL, 32'h89AB_CDEF, NOT_TYPED, 32'h0},
      '{ROW_PIXEL, 32'hFFFF_FFFF, NOT_TYPED, 32'h0},
      '{ROW_PIXEL, 32'h0000_0000, NOT_TYPED, 32'h0},
      '{ROW_PIXEL, 32'hA5A5_A5A5, NOT_TYPED, 32'h0},
      '{ROW_PIXEL, 32'h5A5A_5A5A, NOT_TYPED, 32'h0},
      '{ROW_PIXEL, 32'hFFFF_FFFF, NOT_TYPED, 32'h0}
   };

   box_blur_3x3_rgba #(
      .MAX_SIZE(MAX_SIDE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // size in force: clamp the register into 2 .. MAX_SIDE
   function automatic int unsigned active_side();
      if (side_reg < 2) return 2;
      if (side_reg > MAX_SIDE) return MAX_SIDE;
      return side_reg;
   endfunction

   // lane-wise truncating mean over window rows r0..2 and columns c0..2
   function automatic pixel_type window_mean(input int r0, input int c0);
      int unsigned acc [LANES];
      int unsigned cnt;
      pixel_type   res;
      cnt = 0;
      res = '0;
      foreach (acc[k]) acc[k] = 0;
      for (int r = r0; r < 3; r++) begin
         for (int c = c0; c < 3; c++) begin
            for (int k = 0; k < LANES; k++) acc[k] += win[r][c][k*LANE_W +: LANE_W];
            cnt++;
         end
      end
      for (int k = 0; k < LANES; k++) res[k*LANE_W +: LANE_W] = LANE_W'(acc[k] / cnt);
      return res;
   endfunction

   function automatic blur_word_type centre(input pixel_type pix, input int unsigned r,
                                            input int unsigned c);
      blur_word_type w;
      w.pix  = pix;
      w.row  = POS_W'(r);
      w.col  = POS_W'(c);
      w.last = 1'b0;
      return w;
   endfunction

   // advance the shadow by one pixel and queue the centres it completes
   function automatic void predict_blur(input pixel_type pix, input int typed_n,
                                        input pixel_type typed_pix);
      blur_word_type due [$];
      int unsigned   side;
      int unsigned   r;
      int unsigned   c;
      int            top;
      int            left;
      side = active_side();
      if (next_col >= side) next_col = 0;
      if (next_row >= side) next_row = 0;
      r = next_row;
      c = next_col;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2]    = older_row[c];
      win[1][2]    = newer_row[c];
      win[2][2]    = pix;
      older_row[c] = newer_row[c];
      newer_row[c] = pix;
      // clip the window at the top row and the left column
      top  = (r >= 2) ? 0 : 1;
      left = (c >= 2) ? 0 : 1;
      if (r >= 1) begin
         if (c >= 1) due.push_back(centre(window_mean(top, left), r - 1, c - 1));
         if (c == side - 1) due.push_back(centre(window_mean(top, 1), r - 1, c));
         // last row: the centres of this row are complete too
         if (r == side - 1) begin
            if (c >= 1) due.push_back(centre(window_mean(1, left), r, c - 1));
            if (c == side - 1) due.push_back(centre(window_mean(1, 1), r, c));
         end
      end
      if (due.size() > 0) due[due.size()-1].last = 1'b1;
      if (typed_n != NOT_TYPED) begin
         if (due.size() != typed_n) begin
            $error("result count: expected %0d, got %0d", typed_n, due.size());
            faults++;
         end
         foreach (due[i]) due[i].pix = typed_pix;
      end
      foreach (due[i]) expected_blurs.push_back(due[i]);
      next_col = c + 1;
      if (next_col >= side) begin
         next_col = 0;
         next_row = r + 1;
         if (next_row >= side) next_row = 0;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         if (faults < REPORT_CAP) $error("%s: expected %h, got %h", name, want, got);
         faults++;
      end
   endtask

   // sample both channels and the register port on the edge, values from
   // before the edge; check result words first, then predict from the input
   always @(posedge clock) begin : scoreboard
      blur_word_type  want;
      typed_blur_type typed;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blurs.size() == 0) begin
               $error("result word %h with nothing expected", rsp_tdata);
               faults++;
            end else begin
               want = expected_blurs.pop_front();
               compare_field("out_pixel", want.pix, rsp_tdata[PIXEL_W-1:0]);
               compare_field("out_row", 32'(want.row), 32'(rsp_tdata[ROW_LSB +: POS_W]));
               compare_field("out_col", 32'(want.col), 32'(rsp_tdata[COL_LSB +: POS_W]));
               compare_field("last_in_run", 32'(want.last), 32'(rsp_tlast));
               compare_field("pad", 0, 32'(rsp_tdata[RSP_DATA_W-1:PAD_LSB]));
            end
         end
         // a size write restarts the frame at pixel (0, 0)
         if (csr_wr_en) begin
            side_reg = csr_wr_data;
            next_row = 0;
            next_col = 0;
         end
         if (req_tvalid && req_tready) begin
            typed = typed_blur_q.pop_front();
            predict_blur(req_tdata, typed.n, typed.pix);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: random stalls, and a long hold-off whenever one is asked for
   // ---------------------------------------------------------------------------
   initial begin : result_sink
      int unsigned served;
      rsp_tready = 1'b0;
      served = 0;
      forever begin
         @(posedge clock);
         if (hold_asks != served) begin
            served = hold_asks;
            // hold off for the whole stretch, the block backs up into its input
            rsp_tready <= 1'b0;
            for (int held = 1; held < HOLD_OFF_CYCLES; held++) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------------

   // offer one pixel word, with random idle cycles ahead of it; return on accept
   task automatic send_word(input pixel_type pix, input int typed_n, input pixel_type typed_pix);
      typed_blur_type typed;
      typed.n   = typed_n;
      typed.pix = typed_pix;
      typed_blur_q.push_back(typed);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;   // junk data while idle must be ignored
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // drop valid, wait for every expected word, then let silent items finish
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_blurs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [CFG_W-1:0] side);
      drain();
      csr_wr_data <= side;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mostly random words, with flat and lane-extreme pixels mixed in
   function automatic pixel_type pick_pixel();
      pixel_type p;
      case ($urandom_range(7))
         0: p = '0;
         1: p = '1;
         2: for (int k = 0; k < LANES; k++)
               p[k*LANE_W +: LANE_W] = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
         default: p = $urandom;
      endcase
      return p;
   endfunction

   initial begin : stimulus
      int unsigned side;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_asks     = 0;
      faults        = 0;
      side_reg      = CFG_W'(IMAGE_SIZE_RESET);
      next_row      = 0;
      next_col      = 0;
      foreach (win[i, j]) win[i][j] = '0;
      foreach (older_row[i]) older_row[i] = '0;
      foreach (newer_row[i]) newer_row[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling
      foreach (opening_plan[i]) begin
         if (opening_plan[i].kind == ROW_SIZE)
            write_size(opening_plan[i].value[CFG_W-1:0]);
         else
            send_word(opening_plan[i].value, opening_plan[i].typed_n, opening_plan[i].typed_pix);
      end

      // sizes above range clamp to the maximum; all register bits set once
      write_size(CFG_W'(MAX_SIDE + 1));
      repeat (5) send_word(pick_pixel(), NOT_TYPED, '0);
      write_size('1);
      repeat (5) send_word(pick_pixel(), NOT_TYPED, '0);

      // random phases, small images so frame ends come often; each write
      // restarts the frame, often in the middle of one
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin req_idle_pct = 47; rsp_stall_pct <= 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct <= 47; end
            default: begin req_idle_pct = 30; rsp_stall_pct <= 30; end
         endcase
         case (ph)
            2:       side = 0;
            7:       side = 1;
            9:       side = $urandom_range(7, 12);
            default: side = $urandom_range(2, 6);
         endcase
         write_size(CFG_W'(side));
         // long receiver hold-off while the sender keeps offering
         if (ph == 5) hold_asks <= hold_asks + 1;
         repeat ($urandom_range(18, 32)) send_word(pick_pixel(), NOT_TYPED, '0);
      end

      drain();
      if (faults == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // hard limit on run time, far beyond the slowest correct run
   initial begin : watchdog
      #2_000_000;
      $error("run timed out");
      $display("Some tests failed");
      $finish;
   end

endmodule
